### rtl/crp_pkg.sv
`default_nettype none
package crp_pkg;

  localparam int FOOTER_DEPTH = 1024;
  localparam int OFFSET_BITS  = 48;

  localparam int IDX_W = $clog2(FOOTER_DEPTH);
  localparam int CNT_W = $clog2(FOOTER_DEPTH + 1);

  // datapath is cut into slices, one per cell; operands padded to whole slices
  localparam int SLICE_BITS = 16;
  localparam int NCELL      = (OFFSET_BITS + SLICE_BITS - 1) / SLICE_BITS;
  localparam int PAD_W      = NCELL * SLICE_BITS;
  localparam int SETTLE_W   = (NCELL > 1) ? $clog2(NCELL) : 1;

  localparam int WINDOW_W    = 32;
  localparam int SECTOR_SIZE = 512;
  localparam int SECTOR_BITS = $clog2(SECTOR_SIZE);

  localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = '1;

  localparam logic [WINDOW_W-1:0] WINDOW_RESET = 32'd4096;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_HDR   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } crp_op_t;

  // register word index, taken from paddr[2]
  localparam logic REG_WINDOW = 1'b0;
  localparam logic REG_ALIGN  = 1'b1;

  typedef struct packed {
    logic [1:0]             opcode;
    logic [OFFSET_BITS-1:0] offset;
  } crp_in_t;

  typedef struct packed {
    logic [OFFSET_BITS-1:0] region_start;
    logic [OFFSET_BITS-1:0] region_end;
    logic                   ended_by_footer;
  } crp_out_t;

  // handed from one cell to the next
  typedef struct packed {
    logic carry;
    logic gt;
  } crp_link_t;

  typedef struct packed {
    logic                   gt;
    logic                   ovf;
    logic [OFFSET_BITS-1:0] sum;
  } crp_chain_res_t;

endpackage
`default_nettype wire

### rtl/crp_cell.sv
`default_nettype none
module crp_cell (
  input  wire                            clk,
  input  wire  [crp_pkg::SLICE_BITS-1:0] a_slice,
  input  wire  [crp_pkg::SLICE_BITS-1:0] b_slice,
  input  wire  [crp_pkg::SLICE_BITS-1:0] w_slice,
  input  crp_pkg::crp_link_t             link_in,
  output crp_pkg::crp_link_t             link_out,
  output logic [crp_pkg::SLICE_BITS-1:0] sum_slice
);
  import crp_pkg::*;

  logic [SLICE_BITS:0] add;
  logic                gt_here;

  assign add     = {1'b0, a_slice} + {1'b0, w_slice} + {{SLICE_BITS{1'b0}}, link_in.carry};
  // b > a decided by this slice unless equal, then by the lower slices
  assign gt_here = (b_slice > a_slice) || ((b_slice == a_slice) && link_in.gt);

  always_ff @(posedge clk) begin
    link_out.carry <= add[SLICE_BITS];
    link_out.gt    <= gt_here;
    sum_slice      <= add[SLICE_BITS-1:0];
  end

endmodule
`default_nettype wire

### rtl/crp_chain.sv
`default_nettype none
module crp_chain (
  input  wire                               clk,
  input  wire  [crp_pkg::OFFSET_BITS-1:0]   header,
  input  wire  [crp_pkg::OFFSET_BITS-1:0]   footer,
  input  wire  [crp_pkg::WINDOW_W-1:0]      window,
  output crp_pkg::crp_chain_res_t           res
);
  import crp_pkg::*;

  logic [PAD_W-1:0]                  a_pad;
  logic [PAD_W-1:0]                  b_pad;
  logic [PAD_W-1:0]                  w_pad;
  crp_link_t                         links [NCELL+1];
  logic [NCELL-1:0][SLICE_BITS-1:0]  sums;
  logic [PAD_W:0]                    sum_ext;

  assign a_pad    = PAD_W'(header);
  assign b_pad    = PAD_W'(footer);
  assign w_pad    = PAD_W'(window);
  assign links[0] = '0;

  // carry and compare state walk one cell per cycle; the operands must be
  // held steady until the result is used, which the chain does not enforce
  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    crp_cell u_cell (
      .clk       (clk),
      .a_slice   (a_pad[k*SLICE_BITS +: SLICE_BITS]),
      .b_slice   (b_pad[k*SLICE_BITS +: SLICE_BITS]),
      .w_slice   (w_pad[k*SLICE_BITS +: SLICE_BITS]),
      .link_in   (links[k]),
      .link_out  (links[k+1]),
      .sum_slice (sums[k])
    );
  end

  assign sum_ext = {links[NCELL].carry, sums};
  assign res.gt  = links[NCELL].gt;
  assign res.ovf = |sum_ext[PAD_W:OFFSET_BITS];
  assign res.sum = sum_ext[OFFSET_BITS-1:0];

endmodule
`default_nettype wire

### rtl/carve_region_pairer_unit.sv
`default_nettype none
// Carve region pairer.
// Input channel (in_valid/in_ready/in_data): opcode plus a 48-bit offset.
//   Load beats append a footer end to a 1024-entry store (ignored when full),
//   clear beats empty it, header beats ask for a region.
// Output channel (out_valid/out_ready/out_data): one region per header beat,
//   none for misaligned headers while sector alignment is on.
// APB port: word 0 window length, word 1 sector-align flag; pready always high.
// Load, clear and unused beats are handled in the idle state. For a header
//   the pointer steps over each stored footer not above it; each candidate
//   costs a store read, settling while the carry and compare cross the cell
//   row, and a decide step. The region is registered in the decide step,
//   and the next beat is taken once the unit is back in idle.
// One item is in flight at a time; in_ready is high only between items. A
//   finished region sits in the output register, so the next beat is taken
//   while it waits; a later region holds in the decide step until the
//   receiver drains the register.
// Reset empties the store (count and pointer to zero), drops out_valid and
//   restores window 4096 and alignment on. Store contents are not cleared.
module carve_region_pairer_unit (
  input  wire                clk,
  input  wire                rst,
  input  wire                in_valid,
  output logic               in_ready,
  input  crp_pkg::crp_in_t   in_data,
  output logic               out_valid,
  input  wire                out_ready,
  output crp_pkg::crp_out_t  out_data,
  input  wire                psel,
  input  wire                penable,
  input  wire                pwrite,
  input  wire  [2:0]         paddr,
  input  wire  [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import crp_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_SETTLE,
    S_DECIDE
  } state_t;

  state_t                 state;
  logic [CNT_W-1:0]       count;
  logic [CNT_W-1:0]       ptr;
  logic [OFFSET_BITS-1:0] hdr;
  logic                   have_ft;
  logic [SETTLE_W-1:0]    settle;
  logic [WINDOW_W-1:0]    window;
  logic                   sector;
  logic [OFFSET_BITS-1:0] rd_data;
  logic [OFFSET_BITS-1:0] store [FOOTER_DEPTH];

  crp_chain_res_t         res;
  logic                   in_beat;
  logic                   cfg_wr;
  logic                   do_load;
  logic                   drop;
  logic                   found;
  logic                   emit;

  assign in_ready = (state == S_IDLE);
  assign in_beat  = in_valid && in_ready;
  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;
  assign do_load  = in_beat && (in_data.opcode == OP_LOAD) && (count < CNT_W'(FOOTER_DEPTH));
  assign drop     = sector && (hdr[SECTOR_BITS-1:0] != '0);
  assign found    = have_ft && res.gt;
  assign emit     = (state == S_DECIDE) && !(have_ft && !res.gt) && !drop &&
                    (!out_valid || out_ready);

  always_comb begin
    unique case (paddr[2])
      REG_WINDOW: prdata = window;
      REG_ALIGN:  prdata = {31'b0, sector};
      default:    prdata = '0;
    endcase
  end

  crp_chain u_chain (
    .clk    (clk),
    .header (hdr),
    .footer (rd_data),
    .window (window),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (do_load) begin
      store[count[IDX_W-1:0]] <= in_data.offset;
    end
    if (state == S_READ) begin
      rd_data <= store[ptr[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      ptr       <= '0;
      out_valid <= 1'b0;
      window    <= WINDOW_RESET;
      sector    <= 1'b1;
      have_ft   <= 1'b0;
      settle    <= '0;
    end else begin
      if (cfg_wr) begin
        unique case (paddr[2])
          REG_WINDOW: window <= pwdata;
          REG_ALIGN:  sector <= pwdata[0];
          default:    ;
        endcase
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_beat) begin
            unique case (in_data.opcode)
              OP_LOAD: begin
                if (do_load) begin
                  count <= count + 1'b1;
                end
              end
              OP_HDR: begin
                hdr   <= in_data.offset;
                state <= S_READ;
              end
              OP_CLEAR: begin
                count <= '0;
                ptr   <= '0;
              end
              default: ;
            endcase
          end
        end
        S_READ: begin
          // ptr never passes count, and count never passes the depth
          have_ft <= (ptr < count);
          settle  <= '0;
          state   <= S_SETTLE;
        end
        S_SETTLE: begin
          settle <= settle + 1'b1;
          if (settle == SETTLE_W'(NCELL - 1)) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (have_ft && !res.gt) begin
            ptr   <= ptr + 1'b1;
            state <= S_READ;
          end else if (drop) begin
            state <= S_IDLE;
          end else if (emit) begin
            out_data.region_start    <= hdr;
            out_data.ended_by_footer <= found;
            if (found) begin
              out_data.region_end <= rd_data;
            end else begin
              out_data.region_end <= res.ovf ? OFFSET_MAX : res.sum;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

### rtl/crp_checker.sv
`default_nettype none
module crp_checker (
  input wire                clk,
  input wire                rst,
  input wire                in_valid,
  input wire                in_ready,
  input crp_pkg::crp_in_t   in_data,
  input wire                out_valid,
  input wire                out_ready,
  input crp_pkg::crp_out_t  out_data
);
  import crp_pkg::*;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  // a region never ends before it starts: footer above header, or header plus window saturated at the top
  a_end_order: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.region_end >= out_data.region_start)
    else $error("region end below region start");

  // only a header beat can raise a result
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (in_data.opcode != OP_HDR) |=> !$rose(out_valid))
    else $error("result raised after a non-header beat");

endmodule

bind carve_region_pairer_unit crp_checker u_crp_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire
